[hdl/qsort_pkg.sv]
// Package for the quicksort sorter: constants, state encoding, helpers.
// No dependencies.
package qsort_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int DATA_W       = 32;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_POP,
        ST_PIV,
        ST_SCAN_I,
        ST_SCAN_J,
        ST_SWAP,
        ST_PUSH,
        ST_EMIT_RD,
        ST_EMIT
    } state_t;

    // Order-preserving key for signed compare done as unsigned.
    function automatic logic [DATA_W-1:0] order_key(input logic [DATA_W-1:0] x);
        order_key = x ^ {1'b1, {(DATA_W-1){1'b0}}};
    endfunction

endpackage

[hdl/qsort_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module qsort_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/quicksort_hoare_sorter.sv]
// Quicksort sorter top level (Hoare partition, first element as pivot).
// Depends on qsort_pkg and qsort_ram.
//
// Usage:
//   Input transaction: value/last taken at a clock edge with start high and
//   busy low. One cycle per item while loading. Items past CAPACITY are
//   dropped and flag overflowed on every result of that list.
//   After an item with last, busy rises and the list is sorted in place in
//   the element RAM. Pending ranges sit in a second RAM used as a stack.
//   Each partition pass pops a range and fetches the pivot (ST_POP, ST_PIV),
//   then scans from both ends, comparing one element per cycle except where
//   a swap (ST_SWAP) intervenes, and pushes the subranges (ST_PUSH). RAM
//   reads are registered. Sorted input is the worst case, with O(N^2)
//   comparisons.
//   Results: sorted_value/final_res/overflowed shown for exactly one cycle
//   with strobe high, each result read (ST_EMIT_RD) then shown (ST_EMIT). The
//   receiver cannot stall. busy is already low in the cycle that shows the
//   final result.
//   Reset clears count, overflow flag and control state; RAM contents are
//   not cleared, no clearing pass is needed.
module quicksort_hoare_sorter #(
    parameter int CAPACITY = qsort_pkg::CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic signed [31:0] value,
    input  logic        last,
    output logic        strobe,
    output logic signed [31:0] sorted_value,
    output logic        final_res,
    output logic        overflowed
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = 2 * AW;

    qsort_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [AW:0]   sp_reg, sp_next;
    logic [AW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [AW-1:0] i_reg, i_next, j_reg, j_next;
    logic [31:0]   pk_reg, pk_next, vi_reg, vi_next;
    logic          istep_reg, istep_next;
    logic          push2_reg, push2_next;
    logic          fwd_reg, fwd_next; // element i was just written by the swap
    logic [AW-1:0] p_reg, p_next;
    logic [31:0]   scan_i_data;

    logic          e_we;
    logic [AW-1:0] e_waddr, e_raddr;
    logic [31:0]   e_wdata, e_rdata;
    logic          s_we;
    logic [AW-1:0] s_waddr, s_raddr;
    logic [SW-1:0] s_wdata, s_rdata;

    logic          out_stb_reg, out_stb_next;
    logic          out_fin_reg, out_fin_next;
    logic [31:0]   out_val_reg, out_val_next;
    logic          out_ovf_reg, out_ovf_next;

    qsort_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_elem (
        .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(e_raddr), .rdata(e_rdata)
    );

    qsort_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_stack (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= qsort_pkg::ST_LOAD;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            sp_reg      <= '0;
            fwd_reg     <= 1'b0;
            out_stb_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            sp_reg      <= sp_next;
            fwd_reg     <= fwd_next;
            out_stb_reg <= out_stb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        pk_reg      <= pk_next;
        vi_reg      <= vi_next;
        istep_reg   <= istep_next;
        push2_reg   <= push2_next;
        p_reg       <= p_next;
        out_fin_reg <= out_fin_next;
        out_val_reg <= out_val_next;
        out_ovf_reg <= out_ovf_next;
    end

    assign busy         = (state_reg != qsort_pkg::ST_LOAD);
    assign strobe       = out_stb_reg;
    assign sorted_value = out_val_reg;
    assign final_res    = out_fin_reg;
    assign overflowed   = out_ovf_reg;

    // RAM read of i+1 overlaps the write of j in the swap; when they meet,
    // take the written value.
    assign scan_i_data = fwd_reg ? vi_reg : e_rdata;

    // Scans alternate: a read is issued in one cycle, compared in the next.
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        sp_next      = sp_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        pk_next      = pk_reg;
        vi_next      = vi_reg;
        istep_next   = istep_reg;
        push2_next   = push2_reg;
        fwd_next     = 1'b0;
        p_next       = p_reg;
        out_stb_next = 1'b0;
        out_fin_next = out_fin_reg;
        out_val_next = out_val_reg;
        out_ovf_next = out_ovf_reg;
        e_we         = 1'b0;
        e_waddr      = i_reg;
        e_wdata      = value;
        e_raddr      = i_reg;
        s_we         = 1'b0;
        s_waddr      = sp_reg[AW-1:0];
        s_wdata      = {hi_reg, lo_reg};
        s_raddr      = sp_reg[AW-1:0] - 1'b1;

        case (state_reg)
            qsort_pkg::ST_LOAD:
            begin
                if (start)
                begin
                    if (count_reg < CW'(CAPACITY))
                    begin
                        e_we       = 1'b1;
                        e_waddr    = count_reg[AW-1:0];
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last)
                    begin
                        if (count_next >= CW'(2))
                        begin
                            s_we      = 1'b1;
                            s_waddr   = '0;
                            s_wdata   = {AW'(count_next - 1'b1), AW'(0)};
                            sp_next   = (AW+1)'(1);
                            state_next = qsort_pkg::ST_POP;
                        end
                        else
                        begin
                            i_next     = '0;
                            state_next = qsort_pkg::ST_EMIT_RD;
                        end
                    end
                end
            end

            qsort_pkg::ST_POP:
            begin
                if (sp_reg == '0)
                begin
                    i_next     = '0;
                    state_next = qsort_pkg::ST_EMIT_RD;
                end
                else
                begin
                    // stack read issued this cycle (s_raddr = sp-1)
                    sp_next    = sp_reg - 1'b1;
                    state_next = qsort_pkg::ST_PIV;
                    istep_next = 1'b1;
                end
            end

            qsort_pkg::ST_PIV:
            begin
                if (istep_reg)
                begin
                    lo_next    = s_rdata[AW-1:0];
                    hi_next    = s_rdata[SW-1:AW];
                    e_raddr    = s_rdata[AW-1:0];
                    istep_next = 1'b0;
                end
                else
                begin
                    pk_next    = qsort_pkg::order_key(e_rdata);
                    i_next     = lo_reg;
                    j_next     = hi_reg;
                    e_raddr    = lo_reg;
                    state_next = qsort_pkg::ST_SCAN_I;
                end
            end

            // read of element i is in flight on entry
            qsort_pkg::ST_SCAN_I:
            begin
                if (qsort_pkg::order_key(scan_i_data) < pk_reg)
                begin
                    i_next  = i_reg + 1'b1;
                    e_raddr = i_reg + 1'b1;
                end
                else
                begin
                    vi_next    = scan_i_data;
                    e_raddr    = j_reg;
                    state_next = qsort_pkg::ST_SCAN_J;
                end
            end

            qsort_pkg::ST_SCAN_J:
            begin
                if (qsort_pkg::order_key(e_rdata) > pk_reg)
                begin
                    j_next  = j_reg - 1'b1;
                    e_raddr = j_reg - 1'b1;
                end
                else if (i_reg < j_reg)
                begin
                    // write element j into i now, old i into j next cycle
                    e_we       = 1'b1;
                    e_waddr    = i_reg;
                    e_wdata    = e_rdata;
                    state_next = qsort_pkg::ST_SWAP;
                end
                else
                begin
                    p_next     = j_reg;
                    push2_next = 1'b0;
                    state_next = qsort_pkg::ST_PUSH;
                end
            end

            qsort_pkg::ST_SWAP:
            begin
                e_we       = 1'b1;
                e_waddr    = j_reg;
                e_wdata    = vi_reg;
                i_next     = i_reg + 1'b1;
                j_next     = j_reg - 1'b1;
                e_raddr    = i_reg + 1'b1;
                fwd_next   = (i_reg + 1'b1 == j_reg);
                state_next = qsort_pkg::ST_SCAN_I;
            end

            // push (p+1,hi) then (lo,p)
            qsort_pkg::ST_PUSH:
            begin
                if (!push2_reg)
                begin
                    if (p_reg + 1'b1 < hi_reg && p_reg != hi_reg)
                    begin
                        s_we    = 1'b1;
                        s_wdata = {hi_reg, AW'(p_reg + 1'b1)};
                        sp_next = sp_reg + 1'b1;
                    end
                    push2_next = 1'b1;
                end
                else
                begin
                    if (lo_reg < p_reg)
                    begin
                        s_we    = 1'b1;
                        s_wdata = {p_reg, lo_reg};
                        sp_next = sp_reg + 1'b1;
                    end
                    state_next = qsort_pkg::ST_POP;
                end
            end

            qsort_pkg::ST_EMIT_RD:
            begin
                if (CW'(i_reg) >= count_reg || count_reg == '0)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = qsort_pkg::ST_LOAD;
                end
                else
                begin
                    e_raddr    = i_reg;
                    state_next = qsort_pkg::ST_EMIT;
                end
            end

            qsort_pkg::ST_EMIT:
            begin
                out_stb_next = 1'b1;
                out_val_next = e_rdata;
                out_ovf_next = ovf_reg;
                out_fin_next = (CW'(i_reg) + 1'b1 == count_reg);
                if (CW'(i_reg) + 1'b1 == count_reg)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = qsort_pkg::ST_LOAD;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = qsort_pkg::ST_EMIT_RD;
                end
            end

            default:
            begin
                state_next = qsort_pkg::ST_LOAD;
            end
        endcase
    end

    // Assertions
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("element count beyond capacity");

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= (AW+1)'(CAPACITY))
        else $error("range stack overrun");

    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_stb_reg && !out_fin_reg |-> busy)
        else $error("non-final result while idle");

    a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_stb_reg && out_fin_reg |-> !busy && count_reg == '0)
        else $error("block not emptied after final result");

endmodule

[tb/quicksort_hoare_sorter_test.sv]
// Testbench for quicksort_hoare_sorter: sends lists, predicts the sorted output
// with a behavioral Hoare quicksort and checks every strobed result in order.
// Depends on qsort_pkg and the sorter RTL.
`timescale 1ns / 1ps

module quicksort_hoare_sorter_test;

    localparam int CAP = qsort_pkg::CAPACITY_DEF;

    typedef struct {
        logic signed [31:0] val;
        logic               fin;
        logic               ovf;
    } sorted_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic signed [31:0] value = '0;
    logic last = 1'b0;
    logic busy;
    logic strobe;
    logic signed [31:0] sorted_value;
    logic final_res;
    logic overflowed;

    quicksort_hoare_sorter dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .value(value), .last(last), .strobe(strobe),
        .sorted_value(sorted_value), .final_res(final_res), .overflowed(overflowed)
    );

    always #2 clk = ~clk;

    // predictor state
    logic signed [31:0] list_buf [CAP];
    int                 list_len = 0;
    logic               list_ovf = 1'b0;
    sorted_item_t       pending_sorted [$];

    int  fail_count = 0;
    int  cycle_count = 0;
    bit  quiet_mode = 0;
    bit  big_values = 0;

    // Hoare quicksort with first element as pivot; explicit range stack
    task automatic sort_list();
        int stk_lo [$];
        int stk_hi [$];
        int lo, hi, i, j;
        logic signed [31:0] piv, t;
        stk_lo.push_back(0);
        stk_hi.push_back(list_len - 1);
        while (stk_lo.size() > 0) begin
            lo = stk_lo.pop_back();
            hi = stk_hi.pop_back();
            if (lo < hi) begin
                piv = list_buf[lo];
                i = lo - 1;
                j = hi + 1;
                forever begin
                    do i++; while (list_buf[i] < piv);
                    do j--; while (list_buf[j] > piv);
                    if (i >= j) break;
                    t = list_buf[i];
                    list_buf[i] = list_buf[j];
                    list_buf[j] = t;
                end
                stk_lo.push_back(j + 1);
                stk_hi.push_back(hi);
                stk_lo.push_back(lo);
                stk_hi.push_back(j);
            end
        end
    endtask

    task automatic predict_item(logic signed [31:0] v, logic l);
        sorted_item_t r;
        if (list_len < CAP) begin
            list_buf[list_len] = v;
            list_len++;
        end else begin
            list_ovf = 1'b1;
        end
        if (l) begin
            sort_list();
            for (int k = 0; k < list_len; k++) begin
                r.val = list_buf[k];
                r.fin = (k == list_len - 1);
                r.ovf = list_ovf;
                pending_sorted.push_back(r);
            end
            list_len = 0;
            list_ovf = 1'b0;
        end
    endtask

    // one input transaction, driven at falling edges; start stays high
    // between back-to-back transactions
    task automatic send_item(logic signed [31:0] v, logic l);
        if (!quiet_mode) begin
            while ($urandom_range(99) < 12) begin
                start <= 1'b0;
                @(negedge clk);
            end
        end
        start <= 1'b1;
        value <= v;
        last  <= l;
        do @(posedge clk); while (busy);
        predict_item(v, l);
        @(negedge clk);
    endtask

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(7)) - 3;
            default: return $signed($urandom());
        endcase
    endfunction

    task automatic send_list(int n);
        for (int k = 0; k < n; k++)
            send_item(big_values ? rand_value() : $signed($urandom_range(15)) - 8,
                      k == n - 1);
    endtask

    // result checker
    always @(posedge clk) begin
        sorted_item_t e;
        if (rst_n && strobe) begin
            if (pending_sorted.size() == 0) begin
                $error("unexpected result sorted_value=%0d", sorted_value);
                fail_count++;
            end else begin
                e = pending_sorted.pop_front();
                if (sorted_value !== e.val) begin
                    $error("sorted_value expected %0d actual %0d", e.val, sorted_value);
                    fail_count++;
                end
                if (final_res !== e.fin) begin
                    $error("final_res expected %0b actual %0b", e.fin, final_res);
                    fail_count++;
                end
                if (overflowed !== e.ovf) begin
                    $error("overflowed expected %0b actual %0b", e.ovf, overflowed);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > 2000000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic test_extremes();
        send_item(32'sh7fffffff, 1'b1);
        send_item(32'sh80000000, 1'b0);
        send_item(32'sh7fffffff, 1'b0);
        send_item(32'sh00000000, 1'b0);
        send_item(-32'sd1, 1'b0);
        send_item(32'sh80000000, 1'b1);
    endtask

    task automatic test_duplicates_and_sorted();
        for (int k = 0; k < 5; k++) send_item(32'sd5, k == 4);
        for (int k = 0; k < 6; k++) send_item(k - 2, k == 5);
        for (int k = 0; k < 6; k++) send_item(3 - k, k == 5);
    endtask

    // full list, then two more dropped, the last of them marked last
    task automatic test_overflow();
        big_values = 1;
        for (int k = 0; k < CAP + 2; k++) send_item(rand_value(), k == CAP + 1);
        big_values = 0;
    endtask

    task automatic test_random_lists();
        int sent;
        sent = 0;
        while (sent < 90) begin
            int n;
            quiet_mode = (sent > 20 && sent < 60);
            big_values = $urandom_range(1);
            n = ($urandom_range(9) == 0) ? $urandom_range(CAP) + 1 : $urandom_range(12) + 1;
            if (n > 90 - sent)
                n = 90 - sent;
            send_list(n);
            sent += n;
        end
        quiet_mode = 0;
    endtask

    initial begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_extremes();
        test_duplicates_and_sorted();
        test_overflow();
        test_random_lists();
        start <= 1'b0;
        while (pending_sorted.size() > 0 || busy) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending_sorted.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
